// File: sv/tzr_pkg.sv
// Package for the triangle z-buffer rasterizer: constants, mode codes, FSM states.
// No dependencies.
`default_nettype none
package tzr_pkg;

  localparam int unsigned MaxRowsDef       = 128;
  localparam int unsigned MaxColsDef       = 128;
  localparam int unsigned CoordFracBitsDef = 4;
  localparam int unsigned DepthFracBitsDef = 12;
  localparam logic [7:0]  BackgroundReset  = 8'd50;
  localparam logic [7:0]  ActiveReset      = 8'd128;
  localparam logic [47:0] DepthMin         = {1'b1, 47'd0};
  localparam logic [47:0] DepthMax         = {1'b0, {47{1'b1}}};

  typedef enum logic [1:0] {
    MODE_DRAW  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_BG   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CLEAR,
    ST_WALK,
    ST_DRAIN,
    ST_READ,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// File: sv/tzr_pixel_pipe.sv
// Per-pixel pipeline: edge functions, inside test and saturated depth.
// Depends on tzr_pkg.
`default_nettype none
module tzr_pixel_pipe #(
  parameter int unsigned CoordFracBits = tzr_pkg::CoordFracBitsDef,
  parameter int unsigned AddrWidth     = $clog2(tzr_pkg::MaxRowsDef * tzr_pkg::MaxColsDef)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_vld_i,
  input  wire logic signed [15:0]   ax_i, ay_i, az_i,
  input  wire logic signed [15:0]   bx_i, by_i, bz_i,
  input  wire logic signed [15:0]   cx_i, cy_i, cz_i,
  input  wire logic signed [11:0]   px_i,
  input  wire logic signed [11:0]   py_i,
  input  wire logic [AddrWidth-1:0] addr_i,
  output logic                      out_vld_o,
  output logic [AddrWidth-1:0]      addr_o,
  output logic signed [47:0]        depth_o
);
  import tzr_pkg::*;

  localparam int unsigned Sh = 2 * CoordFracBits;

  // stage 1: edge products
  logic signed [20:0] qx, qy;
  logic signed [41:0] p0a_d, p0b_d, p1a_d, p1b_d, p2a_d, p2b_d;
  logic signed [41:0] p0a_q, p0b_q, p1a_q, p1b_q, p2a_q, p2b_q;
  logic               v1_q, v2_q, v3_q;
  logic [AddrWidth-1:0] a1_q, a2_q, a3_q;

  assign qx = 21'(px_i) <<< CoordFracBits;
  assign qy = 21'(py_i) <<< CoordFracBits;

  always_comb begin
    p0a_d = 42'(21'(cx_i) - 21'(bx_i)) * 42'(qy - 21'(by_i));
    p0b_d = 42'(21'(cy_i) - 21'(by_i)) * 42'(qx - 21'(bx_i));
    p1a_d = 42'(21'(ax_i) - 21'(cx_i)) * 42'(qy - 21'(cy_i));
    p1b_d = 42'(21'(ay_i) - 21'(cy_i)) * 42'(qx - 21'(cx_i));
    p2a_d = 42'(21'(bx_i) - 21'(ax_i)) * 42'(qy - 21'(ay_i));
    p2b_d = 42'(21'(by_i) - 21'(ay_i)) * 42'(qx - 21'(ax_i));
  end

  always_ff @(posedge clk_i) begin
    p0a_q <= p0a_d; p0b_q <= p0b_d;
    p1a_q <= p1a_d; p1b_q <= p1b_d;
    p2a_q <= p2a_d; p2b_q <= p2b_d;
    a1_q  <= addr_i;
  end

  // stage 2: truncate toward zero, inside test
  logic signed [42:0] r0, r1, r2;
  logic signed [42:0] w0_d, w1_d, w2_d, w0_q, w1_q, w2_q;

  function automatic logic signed [42:0] trunc_div(input logic signed [42:0] v);
    logic signed [42:0] t;
    t = v;
    if (v < 0) t = v + 43'((64'd1 << Sh) - 64'd1);
    return t >>> Sh;
  endfunction

  always_comb begin
    r0 = 43'(p0a_q) - 43'(p0b_q);
    r1 = 43'(p1a_q) - 43'(p1b_q);
    r2 = 43'(p2a_q) - 43'(p2b_q);
    w0_d = trunc_div(r0);
    w1_d = trunc_div(r1);
    w2_d = trunc_div(r2);
  end

  always_ff @(posedge clk_i) begin
    w0_q <= w0_d; w1_q <= w1_d; w2_q <= w2_d;
    a2_q <= a1_q;
  end

  // stage 3: depth products (weights non-negative, at most 43 bits)
  logic signed [59:0] m0_q, m1_q, m2_q;
  always_ff @(posedge clk_i) begin
    m0_q <= 60'(az_i) * 60'(w0_q);
    m1_q <= 60'(bz_i) * 60'(w1_q);
    m2_q <= 60'(cz_i) * 60'(w2_q);
    a3_q <= a2_q;
  end

  // valid bits; stage 2 drops pixels outside the triangle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      out_vld_o <= 1'b0;
    end else begin
      v1_q      <= in_vld_i;
      v2_q      <= v1_q && !w0_d[42] && !w1_d[42] && !w2_d[42];
      v3_q      <= v2_q;
      out_vld_o <= v3_q;
    end
  end

  // stage 4: saturating sum in model order
  function automatic logic signed [47:0] sat(input logic signed [61:0] v);
    if (v > 62'(signed'(DepthMax))) return DepthMax;
    if (v < 62'(signed'(DepthMin))) return DepthMin;
    return v[47:0];
  endfunction

  logic signed [47:0] s0, s1, s2;
  always_comb begin
    s0 = sat(62'(m0_q));
    s1 = sat(62'(s0) + 62'(sat(62'(m1_q))));
    s2 = sat(62'(s1) + 62'(sat(62'(m2_q))));
  end

  always_ff @(posedge clk_i) begin
    addr_o    <= a3_q;
    depth_o   <= s2;
  end

endmodule
`default_nettype wire

// File: sv/triangle_zbuffer_rasterizer.sv
// Top level: command FSM, bounding-box walker, frame memories, depth test.
// Depends on tzr_pkg and tzr_pixel_pipe.
//
// Channel | Signals                                   | Handshake
// cmd     | start, mode_i, vert_*_i, fill_color_i,    | taken when start && !busy
//         | pixel_index_i                             |
// result  | done_o, pixel_color_o, pixel_depth_o,     | one-cycle strobe done_o
//         | pixels_written_o                          |
// config  | cfg_we_i, cfg_index_i, cfg_data_i         | written on cfg_we_i
//
// Draw: a setup step, then one pixel per cycle over the clipped bounding box
// (its area sets the time), then an interlock drain while the last depth
// read-modify-writes retire, then the done state. Clear: one entry per cycle
// over all MAX_ROWS*MAX_COLS entries, then the done state. Read: the read
// state, then the done state. done_o strobes the cycle after the done state.
// After reset a pass clears all MAX_ROWS*MAX_COLS entries with busy high. No stalls.
`default_nettype none
module triangle_zbuffer_rasterizer #(
  parameter int unsigned MAX_ROWS        = tzr_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS        = tzr_pkg::MaxColsDef,
  parameter int unsigned COORD_FRAC_BITS = tzr_pkg::CoordFracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         mode_i,
  input  wire logic signed [15:0] vert_a_x_i, vert_a_y_i, vert_a_z_i,
  input  wire logic signed [15:0] vert_b_x_i, vert_b_y_i, vert_b_z_i,
  input  wire logic signed [15:0] vert_c_x_i, vert_c_y_i, vert_c_z_i,
  input  wire logic [23:0]        fill_color_i,
  input  wire logic [13:0]        pixel_index_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  output logic                    done_o,
  output logic [23:0]             pixel_color_o,
  output logic signed [47:0]      pixel_depth_o,
  output logic [14:0]             pixels_written_o
);
  import tzr_pkg::*;

  localparam int unsigned Size  = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(Size);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam logic [AW:0] SizeC = (AW + 1)'(Size);
  localparam int unsigned Lat   = 4;

  // memories
  logic [23:0] color_mem [Size];
  logic [47:0] depth_mem [Size];

  // configuration
  logic [7:0] rows_q, cols_q, bg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ActiveReset;
      cols_q <= ActiveReset;
      bg_q   <= BackgroundReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROWS: rows_q <= cfg_data_i;
        CFG_COLS: cols_q <= cfg_data_i;
        CFG_BG:   bg_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured command
  logic signed [15:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, cx_q, cy_q, cz_q;
  logic [23:0] fill_q;
  logic [13:0] pidx_q;
  logic        accept;
  assign accept = start && !busy;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q <= vert_a_x_i; ay_q <= vert_a_y_i; az_q <= vert_a_z_i;
      bx_q <= vert_b_x_i; by_q <= vert_b_y_i; bz_q <= vert_b_z_i;
      cx_q <= vert_c_x_i; cy_q <= vert_c_y_i; cz_q <= vert_c_z_i;
      fill_q <= fill_color_i;
      pidx_q <= pixel_index_i;
    end
  end

  // bounding box, floored/ceiled and clipped
  logic signed [15:0] mnx, mxx, mny, mxy;
  logic signed [17:0] x0, x1, y0, y1, rlim, clim;
  logic signed [17:0] rows_eff, cols_eff;
  always_comb begin
    mnx = ax_q; if (bx_q < mnx) mnx = bx_q; if (cx_q < mnx) mnx = cx_q;
    mxx = ax_q; if (bx_q > mxx) mxx = bx_q; if (cx_q > mxx) mxx = cx_q;
    mny = ay_q; if (by_q < mny) mny = by_q; if (cy_q < mny) mny = cy_q;
    mxy = ay_q; if (by_q > mxy) mxy = by_q; if (cy_q > mxy) mxy = cy_q;
    x0 = 18'(mnx) >>> COORD_FRAC_BITS;
    y0 = 18'(mny) >>> COORD_FRAC_BITS;
    x1 = (18'(mxx) + 18'((1 << COORD_FRAC_BITS) - 1)) >>> COORD_FRAC_BITS;
    y1 = (18'(mxy) + 18'((1 << COORD_FRAC_BITS) - 1)) >>> COORD_FRAC_BITS;
    rows_eff = (32'(rows_q) > MAX_ROWS) ? 18'(MAX_ROWS) : 18'(rows_q);
    cols_eff = (32'(cols_q) > MAX_COLS) ? 18'(MAX_COLS) : 18'(cols_q);
    rlim = rows_eff - 18'sd2;
    clim = cols_eff - 18'sd2;
    if (x0 < 0) x0 = '0;
    if (y0 < 0) y0 = '0;
    if (x1 > clim) x1 = clim;
    if (y1 > rlim) y1 = rlim;
  end

  // FSM
  state_e      state_q, state_d;
  logic [AW:0] cnt_q, cnt_d;
  logic signed [17:0] x_q, x_d, y_q, y_d, bx0_q, bx1_q, by0_q, by1_q;
  logic [14:0] wcnt_q, wcnt_d;
  logic        walk_vld;
  logic        clr_we;
  logic [23:0] clr_color;
  logic        rd_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      wcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      x_q     <= x_d;
      y_q     <= y_d;
      wcnt_q  <= wcnt_d;
    end
  end

  // box latched in the cycle after accept (ST_WALK setup)
  logic box_go_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) box_go_q <= 1'b0;
    else         box_go_q <= accept && (mode_i == MODE_DRAW);
  end
  always_ff @(posedge clk_i) begin
    if (box_go_q) begin
      bx0_q <= x0; bx1_q <= x1; by0_q <= y0; by1_q <= y1;
    end
  end

  logic inc_w;
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    x_d       = x_q;
    y_d       = y_q;
    wcnt_d    = wcnt_q;
    busy      = 1'b1;
    walk_vld  = 1'b0;
    clr_we    = 1'b0;
    clr_color = {bg_q, bg_q, bg_q};
    rd_en     = 1'b0;
    if (inc_w) wcnt_d = wcnt_q + 15'd1;
    unique case (state_q)
      ST_INIT: begin
        clr_we    = 1'b1;
        clr_color = '0;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == SizeC - 1'b1) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cnt_d  = '0;
          wcnt_d = '0;
          unique case (mode_e'(mode_i))
            MODE_DRAW:  state_d = ST_WALK;
            MODE_CLEAR: state_d = ST_CLEAR;
            MODE_READ:  state_d = ST_READ;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        clr_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == SizeC - 1'b1) state_d = ST_DONE;
      end
      ST_WALK: begin
        if (cnt_q == '0) begin
          // box becomes valid this cycle
          cnt_d = (AW + 1)'(1);
          x_d   = x0;
          y_d   = y0;
          if (x0 > x1 || y0 > y1) begin
            state_d = ST_DRAIN;
            cnt_d   = '0;
          end
        end else begin
          walk_vld = 1'b1;
          if (y_q == by1_q) begin
            y_d = by0_q;
            x_d = x_q + 18'sd1;
            if (x_q == bx1_q) begin
              state_d = ST_DRAIN;
              cnt_d   = '0;
            end
          end else begin
            y_d = y_q + 18'sd1;
          end
        end
      end
      ST_DRAIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW + 1)'(Lat + 4)) state_d = ST_DONE;
      end
      ST_READ: begin
        rd_en = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW + 1)'(1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // walker address: stored row = rows-1-y
  logic [AW-1:0] waddr;
  logic [17:0] srow;
  assign srow  = 18'(rows_eff - 18'sd1 - y_q);
  assign waddr = AW'(srow[RW-1:0] * MAX_COLS + 32'(x_q[CW-1:0]));

  logic [AW-1:0] paddr;
  logic          pvld;
  logic signed [47:0] pdepth;

  tzr_pixel_pipe #(.CoordFracBits(COORD_FRAC_BITS), .AddrWidth(AW)) u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (walk_vld),
    .ax_i(ax_q), .ay_i(ay_q), .az_i(az_q),
    .bx_i(bx_q), .by_i(by_q), .bz_i(bz_q),
    .cx_i(cx_q), .cy_i(cy_q), .cz_i(cz_q),
    .px_i     (x_q[11:0]),
    .py_i     (y_q[11:0]),
    .addr_i   (waddr),
    .out_vld_o(pvld),
    .addr_o   (paddr),
    .depth_o  (pdepth)
  );

  // depth read stage; pixels of one triangle never repeat and the drain
  // retires every write before the next command, so no entry is read while
  // its write is pending
  logic [47:0] drd_q;
  logic [23:0] crd_q;
  logic        tv_q;
  logic [AW-1:0] ta_q;
  logic signed [47:0] td_q;
  logic [AW-1:0] raddr;
  assign raddr = rd_en ? AW'(pidx_q) : paddr;

  always_ff @(posedge clk_i) begin
    drd_q <= depth_mem[raddr];
    crd_q <= color_mem[raddr];
    ta_q  <= paddr;
    td_q  <= pdepth;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tv_q <= 1'b0;
    else         tv_q <= pvld;
  end

  logic do_w;
  assign do_w  = tv_q && ($signed(drd_q) < td_q);
  assign inc_w = do_w;

  // memory writes
  always_ff @(posedge clk_i) begin
    if (clr_we) begin
      depth_mem[cnt_q[AW-1:0]] <= DepthMin;
      color_mem[cnt_q[AW-1:0]] <= clr_color;
    end else if (do_w) begin
      depth_mem[ta_q] <= td_q;
      color_mem[ta_q] <= fill_q;
    end
  end

  // result
  logic [1:0] mode_q;
  always_ff @(posedge clk_i) if (accept) mode_q <= mode_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= (state_q == ST_DONE);
  end
  always_ff @(posedge clk_i) begin
    pixel_color_o    <= '0;
    pixel_depth_o    <= '0;
    pixels_written_o <= '0;
    if (mode_q == MODE_READ && 32'(pidx_q) < Size) begin
      pixel_color_o <= crd_q;
      pixel_depth_o <= drd_q;
    end
    if (mode_q == MODE_DRAW) pixels_written_o <= wcnt_q;
  end

endmodule
`default_nettype wire

// File: sim/tb_triangle_zbuffer_rasterizer.sv
// Testbench for triangle_zbuffer_rasterizer: directed and random draw, clear and read commands,
// checked against an in-bench frame/depth buffer predictor. Depends on tzr_pkg and the RTL.
`timescale 1ns / 1ps
module tb_triangle_zbuffer_rasterizer;
  import tzr_pkg::*;

  localparam int  StoreSize  = MaxRowsDef * MaxColsDef;
  localparam int  CycleLimit = 4000000;
  localparam int  ItemsPerPhase = 335;

  typedef struct {
    mode_e              mode;
    logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [23:0]        fill;
    logic [13:0]        idx;
  } raster_cmd_t;

  typedef struct {
    logic [23:0]        color;
    logic signed [47:0] depth;
    logic [14:0]        count;
  } raster_res_t;

  // Frame buffer model plus queue of pending results
  class raster_scoreboard;
    logic [23:0] color_mem[StoreSize];
    longint      depth_mem[StoreSize];
    int unsigned rows_reg, cols_reg, bg_reg;
    raster_res_t pending[$];
    int          errors;

    function void reset_state();
      for (int i = 0; i < StoreSize; i++) begin
        color_mem[i] = '0;
        depth_mem[i] = -(64'sd1 <<< 47);
      end
      rows_reg = ActiveReset;
      cols_reg = ActiveReset;
      bg_reg   = BackgroundReset;
      errors   = 0;
    endfunction

    function void write_reg(cfg_idx_e sel, logic [7:0] val);
      case (sel)
        CFG_ROWS: rows_reg = val;
        CFG_COLS: cols_reg = val;
        CFG_BG:   bg_reg   = val;
        default: ;
      endcase
    endfunction

    function longint floor_px(longint v);
      return v >>> CoordFracBitsDef;
    endfunction

    function longint sat(longint v);
      longint hi, lo;
      hi = (64'sd1 <<< 47) - 1;
      lo = -(64'sd1 <<< 47);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // Edge value, truncated toward zero to whole pixels squared
    function longint edge_val(longint ax, longint ay, longint bx, longint by,
                              longint px, longint py);
      longint raw;
      raw = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
      return raw / (64'sd1 <<< (2 * CoordFracBitsDef));
    endfunction

    function int unsigned rasterize(raster_cmd_t c);
      longint ax, ay, az, bx, by, bz, cx, cy, cz;
      longint x0, x1, y0, y1, rows, cols, px, py, w0, w1, w2, d, addr;
      int unsigned n;
      ax = c.ax; ay = c.ay; az = c.az;
      bx = c.bx; by = c.by; bz = c.bz;
      cx = c.cx; cy = c.cy; cz = c.cz;
      rows = (rows_reg > MaxRowsDef) ? MaxRowsDef : rows_reg;
      cols = (cols_reg > MaxColsDef) ? MaxColsDef : cols_reg;
      x0 = floor_px((ax < bx) ? ((ax < cx) ? ax : cx) : ((bx < cx) ? bx : cx));
      y0 = floor_px((ay < by) ? ((ay < cy) ? ay : cy) : ((by < cy) ? by : cy));
      x1 = -floor_px(-((ax > bx) ? ((ax > cx) ? ax : cx) : ((bx > cx) ? bx : cx)));
      y1 = -floor_px(-((ay > by) ? ((ay > cy) ? ay : cy) : ((by > cy) ? by : cy)));
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > cols - 2) x1 = cols - 2;
      if (y1 > rows - 2) y1 = rows - 2;
      n = 0;
      for (longint x = x0; x <= x1; x++) begin
        for (longint y = y0; y <= y1; y++) begin
          px = x <<< CoordFracBitsDef;
          py = y <<< CoordFracBitsDef;
          w0 = edge_val(bx, by, cx, cy, px, py);
          w1 = edge_val(cx, cy, ax, ay, px, py);
          w2 = edge_val(ax, ay, bx, by, px, py);
          if (w0 < 0 || w1 < 0 || w2 < 0) continue;
          d = sat(az * w0);
          d = sat(d + sat(bz * w1));
          d = sat(d + sat(cz * w2));
          addr = (rows - 1 - y) * MaxColsDef + x;
          if (depth_mem[addr] < d) begin
            depth_mem[addr] = d;
            color_mem[addr] = c.fill;
            n++;
          end
        end
      end
      return n;
    endfunction

    // Accepted command: update the model and queue its result
    function void note_command(raster_cmd_t c);
      raster_res_t r;
      logic [7:0] g;
      r = '{default: '0};
      case (c.mode)
        MODE_DRAW: r.count = rasterize(c);
        MODE_CLEAR: begin
          g = bg_reg;
          for (int i = 0; i < StoreSize; i++) begin
            color_mem[i] = {g, g, g};
            depth_mem[i] = -(64'sd1 <<< 47);
          end
        end
        MODE_READ: begin
          r.color = color_mem[c.idx];
          r.depth = depth_mem[c.idx];
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [23:0] color, logic signed [47:0] depth,
                               logic [14:0] count);
      raster_res_t e;
      if (pending.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (color !== e.color) begin
        $error("pixel_color: expected %h, got %h", e.color, color);
        errors++;
      end
      if (depth !== e.depth) begin
        $error("pixel_depth: expected %0d, got %0d", e.depth, depth);
        errors++;
      end
      if (count !== e.count) begin
        $error("pixels_written: expected %0d, got %0d", e.count, count);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode_i = '0;
  logic signed [15:0] vert_a_x_i = '0, vert_a_y_i = '0, vert_a_z_i = '0;
  logic signed [15:0] vert_b_x_i = '0, vert_b_y_i = '0, vert_b_z_i = '0;
  logic signed [15:0] vert_c_x_i = '0, vert_c_y_i = '0, vert_c_z_i = '0;
  logic [23:0]        fill_color_i = '0;
  logic [13:0]        pixel_index_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [7:0]         cfg_data_i = '0;
  logic               done_o;
  logic [23:0]        pixel_color_o;
  logic signed [47:0] pixel_depth_o;
  logic [14:0]        pixels_written_o;

  raster_scoreboard sb = new();
  int unsigned      cycle_cnt = 0;

  triangle_zbuffer_rasterizer u_top (
    .clk_i, .rst_ni, .start, .busy, .mode_i,
    .vert_a_x_i, .vert_a_y_i, .vert_a_z_i,
    .vert_b_x_i, .vert_b_y_i, .vert_b_z_i,
    .vert_c_x_i, .vert_c_y_i, .vert_c_z_i,
    .fill_color_i, .pixel_index_i,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .done_o, .pixel_color_o, .pixel_depth_o, .pixels_written_o
  );

  always #5 clk_i = ~clk_i;

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(pixel_color_o, pixel_depth_o, pixels_written_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one command and hold it until the block takes it
  task automatic send_cmd(raster_cmd_t c);
    start         <= 1'b1;
    mode_i        <= c.mode;
    vert_a_x_i    <= c.ax; vert_a_y_i <= c.ay; vert_a_z_i <= c.az;
    vert_b_x_i    <= c.bx; vert_b_y_i <= c.by; vert_b_z_i <= c.bz;
    vert_c_x_i    <= c.cx; vert_c_y_i <= c.cy; vert_c_z_i <= c.cz;
    fill_color_i  <= c.fill;
    pixel_index_i <= c.idx;
    do @(posedge clk_i); while (busy);
    sb.note_command(c);
  endtask

  // Drain outstanding results, then let the block settle
  task automatic wait_quiet();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // One register write, after which the write port returns to idle
  task automatic write_cfg(cfg_idx_e sel, logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.write_reg(sel, val);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic raster_cmd_t rand_fields(mode_e m);
    raster_cmd_t c;
    c.mode = m;
    c.ax = $urandom; c.ay = $urandom; c.az = $urandom;
    c.bx = $urandom; c.by = $urandom; c.bz = $urandom;
    c.cx = $urandom; c.cy = $urandom; c.cz = $urandom;
    c.fill = $urandom;
    c.idx  = $urandom;
    return c;
  endfunction

  // Small triangle near the active area, vertices within about 12 pixels of a center
  function automatic raster_cmd_t small_tri();
    raster_cmd_t c;
    int cxp, cyp, lim_c, lim_r;
    c = rand_fields(MODE_DRAW);
    lim_c = (sb.cols_reg > MaxColsDef) ? MaxColsDef : sb.cols_reg;
    lim_r = (sb.rows_reg > MaxRowsDef) ? MaxRowsDef : sb.rows_reg;
    cxp = ($urandom_range(0, lim_c + 8) - 4) * 16;
    cyp = ($urandom_range(0, lim_r + 8) - 4) * 16;
    c.ax = cxp + $urandom_range(0, 400) - 200;
    c.ay = cyp + $urandom_range(0, 400) - 200;
    c.bx = cxp + $urandom_range(0, 400) - 200;
    c.by = cyp + $urandom_range(0, 400) - 200;
    c.cx = cxp + $urandom_range(0, 400) - 200;
    c.cy = cyp + $urandom_range(0, 400) - 200;
    return c;
  endfunction

  // Read address biased toward the active area
  function automatic raster_cmd_t read_cmd();
    raster_cmd_t c;
    int lim_c;
    c = rand_fields(MODE_READ);
    lim_c = (sb.cols_reg > MaxColsDef) ? MaxColsDef : sb.cols_reg;
    if ($urandom_range(0, 99) < 75)
      c.idx = $urandom_range(0, MaxRowsDef - 1) * MaxColsDef + $urandom_range(0, lim_c - 1);
    return c;
  endfunction

  task automatic run_random(int unsigned n, int unsigned idle_pct);
    raster_cmd_t c;
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 999);
      if (r < 5)        c = rand_fields(MODE_CLEAR);
      else if (r < 15)  c = rand_fields(MODE_NONE);
      else if (r < 25)  c = rand_fields(MODE_DRAW);
      else if (r < 650) c = small_tri();
      else              c = read_cmd();
      if ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      send_cmd(c);
    end
  endtask

  // Directed corner cases
  task automatic run_directed();
    raster_cmd_t c;
    send_cmd(rand_fields(MODE_CLEAR));
    // full-screen triangle, in both windings
    c = rand_fields(MODE_DRAW);
    c.ax = 16'sh8000; c.ay = 16'sh8000; c.bx = 16'sh7fff; c.by = 16'sh8000;
    c.cx = 16'sh0000; c.cy = 16'sh7fff; c.az = 16'sh7fff; c.bz = 16'sh7fff;
    c.cz = 16'sh7fff; c.fill = 24'hffffff;
    send_cmd(c);
    c.bx = 16'sh0000; c.by = 16'sh7fff; c.cx = 16'sh7fff; c.cy = 16'sh8000;
    c.fill = 24'h000000;
    send_cmd(c);
    // small triangle, positive winding, most negative depth
    c = rand_fields(MODE_DRAW);
    c.ax = 16'sd16; c.ay = 16'sd16; c.bx = 16'sd160; c.by = 16'sd16;
    c.cx = 16'sd16; c.cy = 16'sd160;
    c.az = 16'sh8000; c.bz = 16'sh8000; c.cz = 16'sh8000; c.fill = 24'h123456;
    send_cmd(c);
    c.bx = 16'sd16; c.by = 16'sd160; c.cx = 16'sd160; c.cy = 16'sd16;
    send_cmd(c);
    // degenerate: all vertices at one fractional point, and on a line
    c.ax = 16'sd40; c.ay = 16'sd40; c.bx = 16'sd40; c.by = 16'sd40;
    c.cx = 16'sd40; c.cy = 16'sd40; c.az = 16'sd0; c.bz = 16'sd0; c.cz = 16'sd0;
    send_cmd(c);
    c.cx = 16'sd200; c.cy = 16'sd200; c.bx = 16'sd100; c.by = 16'sd100;
    send_cmd(c);
    // entirely off screen on the negative side
    c.ax = -16'sd300; c.ay = -16'sd300; c.bx = -16'sd20; c.by = -16'sd300;
    c.cx = -16'sd300; c.cy = -16'sd20;
    send_cmd(c);
    // reads at the extremes of the address range and at drawn pixels
    c = rand_fields(MODE_READ); c.idx = '0;      send_cmd(c);
    c.idx = 14'h3fff;                            send_cmd(c);
    c.idx = 126 * MaxColsDef + 1;                send_cmd(c);
    c.idx = 127 * MaxColsDef + 1;                send_cmd(c);
    c.idx = 64 * MaxColsDef + 64;                send_cmd(c);
    // unused mode changes nothing
    send_cmd(rand_fields(MODE_NONE));
    c.idx = 126 * MaxColsDef + 2;                send_cmd(c);
  endtask

  initial begin
    sb.reset_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();

    // phase 1: no idling, full screen, bright background
    wait_quiet();
    write_cfg(CFG_ROWS, 8'd128);
    write_cfg(CFG_COLS, 8'd128);
    write_cfg(CFG_BG, 8'd255);
    send_cmd(rand_fields(MODE_CLEAR));
    run_random(ItemsPerPhase, 0);

    // phase 2: frequent sender gaps, smallest height, oversized width
    wait_quiet();
    write_cfg(CFG_ROWS, 8'd2);
    write_cfg(CFG_COLS, 8'd200);
    write_cfg(CFG_BG, 8'd0);
    send_cmd(rand_fields(MODE_CLEAR));
    run_random(ItemsPerPhase, 77);

    // phase 3: no idling, oversized height, smallest width
    wait_quiet();
    write_cfg(CFG_ROWS, 8'd255);
    write_cfg(CFG_COLS, 8'd2);
    write_cfg(CFG_BG, 8'h5a);
    send_cmd(rand_fields(MODE_CLEAR));
    run_random(ItemsPerPhase, 0);

    // phase 4: light gaps, odd sizes
    wait_quiet();
    write_cfg(CFG_ROWS, 8'd37);
    write_cfg(CFG_COLS, 8'd91);
    write_cfg(CFG_BG, 8'haa);
    send_cmd(rand_fields(MODE_CLEAR));
    run_random(ItemsPerPhase, 27);

    wait_quiet();
    repeat (32) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/tzr_pkg.sv
sv/tzr_pixel_pipe.sv
sv/triangle_zbuffer_rasterizer.sv
sim/tb_triangle_zbuffer_rasterizer.sv
